FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hdl/cjkwj_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cjkwj_pkg;

   localparam int UNIT_W = 16;

   // Two-bit codes kept in the run store.
   localparam logic [1:0] WS_SPACE = 2'd0;
   localparam logic [1:0] WS_TAB   = 2'd1;
   localparam logic [1:0] WS_CR    = 2'd2;
   localparam logic [1:0] WS_LF    = 2'd3;

   localparam logic [UNIT_W-1:0] UNIT_SPACE = 16'h0020;
   localparam logic [UNIT_W-1:0] UNIT_TAB   = 16'h0009;
   localparam logic [UNIT_W-1:0] UNIT_CR    = 16'h000D;
   localparam logic [UNIT_W-1:0] UNIT_LF    = 16'h000A;

   localparam logic [UNIT_W-1:0] CJK_A_LO   = 16'h3400;
   localparam logic [UNIT_W-1:0] CJK_A_HI   = 16'h9FFF;
   localparam logic [UNIT_W-1:0] CJK_B_LO   = 16'hF900;
   localparam logic [UNIT_W-1:0] CJK_B_HI   = 16'hFAFF;
   localparam logic [20:0]       CJK_C_LO   = 21'h20000;
   localparam logic [20:0]       CJK_C_HI   = 21'h323AF;
   localparam logic [20:0]       SUPP_BASE  = 21'h10000;
   localparam logic [UNIT_W-1:0] HIGH_LO    = 16'hD800;
   localparam logic [UNIT_W-1:0] HIGH_HI    = 16'hDBFF;
   localparam logic [UNIT_W-1:0] LOW_LO     = 16'hDC00;
   localparam logic [UNIT_W-1:0] LOW_HI     = 16'hDFFF;

   // Where the next result unit comes from.
   typedef enum logic [1:0] {
      SRC_RUN,
      SRC_HIGH,
      SRC_UNIT
   } src_type;

   typedef struct packed {
      logic    accept;    // request taken this cycle
      logic    emit;      // load the result register
      src_type src;
      logic    last;      // final result of the request
      logic    wr_pend;   // commit the deferred run store write
   } cmd_type;

   typedef struct packed {
      logic plan_run;
      logic plan_high;
      logic plan_unit;
      logic run_last;
      logic out_free;
   } status_type;

   function automatic logic is_ws(input logic [UNIT_W-1:0] u);
      return (u == UNIT_SPACE) || (u == UNIT_TAB) || (u == UNIT_CR) || (u == UNIT_LF);
   endfunction

   function automatic logic [1:0] ws_code(input logic [UNIT_W-1:0] u);
      logic [1:0] code;
      case (u)
         UNIT_TAB: code = WS_TAB;
         UNIT_CR:  code = WS_CR;
         UNIT_LF:  code = WS_LF;
         default:  code = WS_SPACE;
      endcase
      return code;
   endfunction

   function automatic logic [UNIT_W-1:0] ws_unit(input logic [1:0] code);
      logic [UNIT_W-1:0] u;
      case (code)
         WS_SPACE: u = UNIT_SPACE;
         WS_TAB:   u = UNIT_TAB;
         WS_CR:    u = UNIT_CR;
         default:  u = UNIT_LF;
      endcase
      return u;
   endfunction

   function automatic logic is_high(input logic [UNIT_W-1:0] u);
      return (u >= HIGH_LO) && (u <= HIGH_HI);
   endfunction

   function automatic logic is_low(input logic [UNIT_W-1:0] u);
      return (u >= LOW_LO) && (u <= LOW_HI);
   endfunction

   function automatic logic is_cjk_bmp(input logic [UNIT_W-1:0] u);
      return ((u >= CJK_A_LO) && (u <= CJK_A_HI)) || ((u >= CJK_B_LO) && (u <= CJK_B_HI));
   endfunction

   // The high unit is always a high surrogate here, so its offset is its low ten bits.
   function automatic logic pair_is_cjk(input logic [UNIT_W-1:0] hi,
                                        input logic [UNIT_W-1:0] lo);
      logic [20:0] cp;
      cp = SUPP_BASE + {1'b0, hi[9:0], lo[9:0]};
      return (cp >= CJK_C_LO) && (cp <= CJK_C_HI);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/cjkwj_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface cjkwj_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        page_end;

   modport source (output valid, output code_unit, output page_end, input ready);
   modport sink (input valid, input code_unit, input page_end, output ready);
endinterface

interface cjkwj_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_unit;
   logic        last_of_item;
   logic        page_done;
   logic        run_truncated;

   modport source (output valid, output out_unit, output last_of_item, output page_done,
                   output run_truncated, input ready);
   modport sink (input valid, input out_unit, input last_of_item, input page_done,
                 input run_truncated, output ready);
endinterface

`default_nettype wire

FILE: hdl/cjkwj_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cjkwj_datapath #(
   parameter int RUN_DEPTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [15:0]         req_code_unit,
   input  wire logic                req_page_end,
   input  wire cjkwj_pkg::cmd_type  cmd,
   output cjkwj_pkg::status_type    status,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic [15:0]              rsp_out_unit,
   output logic                     rsp_last_of_item,
   output logic                     rsp_page_done,
   output logic                     rsp_run_truncated
);

   localparam int CNT_W = $clog2(RUN_DEPTH + 1);
   localparam int IDX_W = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

   // Page state.
   logic             prev_cjk_ff, prev_cjk_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             held_valid_ff, held_valid_in;
   logic [15:0]      held_unit_ff, held_unit_in;
   logic             pair_ff, pair_in;
   logic             ovf_ff, ovf_in;
   logic             pend_ff, pend_in;
   logic [1:0]       pend_code_ff, pend_code_in;

   // Per-request emission context.
   logic [CNT_W-1:0] run_len_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [15:0]      high_out_ff;
   logic [15:0]      unit_out_ff;
   logic             end_ff;
   logic             trunc_ff;

   logic [1:0]       store_mem [RUN_DEPTH];
   logic [1:0]       rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [1:0]       wr_code;

   logic             out_valid_ff;
   logic [15:0]      out_unit_ff;
   logic             out_last_ff, out_done_ff, out_trunc_ff;

   logic             plan_run, plan_high, plan_unit, trunc;
   logic             store_wr;
   logic             u_ws, u_high, u_low, u_cjk, p_cjk, c_nz, room;
   logic [15:0]      sel_unit;

   always_comb begin
      u_ws   = cjkwj_pkg::is_ws(req_code_unit);
      u_high = cjkwj_pkg::is_high(req_code_unit);
      u_low  = cjkwj_pkg::is_low(req_code_unit);
      u_cjk  = cjkwj_pkg::is_cjk_bmp(req_code_unit);
      p_cjk  = cjkwj_pkg::pair_is_cjk(held_unit_ff, req_code_unit);
      c_nz   = (count_ff != '0);
      room   = (count_ff < CNT_W'(RUN_DEPTH));

      prev_cjk_in   = prev_cjk_ff;
      count_in      = count_ff;
      held_valid_in = held_valid_ff;
      held_unit_in  = held_unit_ff;
      pair_in       = pair_ff;
      ovf_in        = ovf_ff;
      pend_in       = pend_ff;
      pend_code_in  = pend_code_ff;
      plan_run      = 1'b0;
      plan_high     = 1'b0;
      plan_unit     = 1'b0;
      trunc         = 1'b0;
      store_wr      = 1'b0;

      if (held_valid_ff) begin
         // The held high surrogate is classified by this unit.
         plan_high     = 1'b1;
         held_valid_in = 1'b0;
         trunc         = ovf_ff;
         ovf_in        = 1'b0;
         pair_in       = 1'b0;
         count_in      = '0;
         if (u_low) begin
            plan_run    = !(prev_cjk_ff && p_cjk);
            plan_unit   = 1'b1;
            prev_cjk_in = p_cjk;
         end else begin
            plan_run = 1'b1;
            if (u_ws && !req_page_end) begin
               // A new run starts; its first entry is written after the old run is read.
               count_in     = CNT_W'(1);
               pend_in      = 1'b1;
               pend_code_in = cjkwj_pkg::ws_code(req_code_unit);
               prev_cjk_in  = 1'b0;
            end else begin
               plan_unit = 1'b1;
               if (u_high) begin
                  pair_in      = 1'b1;
                  held_unit_in = req_code_unit;
                  prev_cjk_in  = 1'b0;
               end else if (u_ws) begin
                  prev_cjk_in = 1'b0;
               end else begin
                  prev_cjk_in = u_cjk;
               end
            end
         end
      end else if (u_ws) begin
         pair_in = 1'b0;
         if (room) begin
            store_wr = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_page_end) begin
            plan_run  = 1'b1;
            plan_unit = room;
            trunc     = ovf_ff || !room;
         end
      end else if (c_nz) begin
         trunc = ovf_ff;
         if (u_high && !req_page_end) begin
            held_valid_in = 1'b1;
            held_unit_in  = req_code_unit;
         end else begin
            plan_run    = u_high || !(prev_cjk_ff && u_cjk);
            plan_unit   = 1'b1;
            prev_cjk_in = u_cjk && !u_high;
            pair_in     = 1'b0;
            count_in    = '0;
            ovf_in      = 1'b0;
         end
      end else begin
         plan_unit = 1'b1;
         if (pair_ff && u_low) begin
            prev_cjk_in = p_cjk;
            pair_in     = 1'b0;
         end else if (u_high) begin
            pair_in      = 1'b1;
            held_unit_in = req_code_unit;
            prev_cjk_in  = 1'b0;
         end else begin
            pair_in     = 1'b0;
            prev_cjk_in = u_cjk;
         end
      end

      if (req_page_end) begin
         count_in      = '0;
         ovf_in        = 1'b0;
         prev_cjk_in   = 1'b0;
         pair_in       = 1'b0;
         held_valid_in = 1'b0;
      end

      if (cmd.wr_pend) begin
         pend_in = 1'b0;
      end
   end

   assign status.plan_run  = plan_run && c_nz;
   assign status.plan_high = plan_high;
   assign status.plan_unit = plan_unit;
   assign status.run_last  = (CNT_W'(idx_ff) == run_len_ff - CNT_W'(1));
   assign status.out_free  = !out_valid_ff || rsp_ready;

   // One write port: new run entries at accept, the deferred first entry later.
   always_comb begin
      wr_en   = (cmd.accept && store_wr) || (cmd.wr_pend && pend_ff);
      wr_addr = cmd.accept ? count_ff[IDX_W-1:0] : '0;
      wr_code = cmd.accept ? cjkwj_pkg::ws_code(req_code_unit) : pend_code_ff;
   end

   always_comb begin
      if (cmd.accept) begin
         rd_addr = '0;
      end else if (cmd.emit && (cmd.src == cjkwj_pkg::SRC_RUN)) begin
         rd_addr = idx_ff + IDX_W'(1);
      end else begin
         rd_addr = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_code;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_comb begin
      case (cmd.src)
         cjkwj_pkg::SRC_RUN:  sel_unit = cjkwj_pkg::ws_unit(rd_data_ff);
         cjkwj_pkg::SRC_HIGH: sel_unit = high_out_ff;
         default:             sel_unit = unit_out_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_cjk_ff   <= 1'b0;
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
         held_unit_ff  <= '0;
         pair_ff       <= 1'b0;
         ovf_ff        <= 1'b0;
         pend_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            prev_cjk_ff   <= prev_cjk_in;
            count_ff      <= count_in;
            held_valid_ff <= held_valid_in;
            held_unit_ff  <= held_unit_in;
            pair_ff       <= pair_in;
            ovf_ff        <= ovf_in;
            pend_ff       <= pend_in;
         end else if (cmd.wr_pend) begin
            pend_ff <= 1'b0;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pend_code_ff <= pend_code_in;
         run_len_ff   <= count_ff;
         idx_ff       <= '0;
         high_out_ff  <= held_unit_ff;
         unit_out_ff  <= req_code_unit;
         end_ff       <= req_page_end;
         trunc_ff     <= trunc;
      end else if (cmd.emit && (cmd.src == cjkwj_pkg::SRC_RUN)) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.emit) begin
         out_unit_ff  <= sel_unit;
         out_last_ff  <= cmd.last;
         out_done_ff  <= cmd.last && end_ff;
         out_trunc_ff <= trunc_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_unit      = out_unit_ff;
   assign rsp_last_of_item  = out_last_ff;
   assign rsp_page_done     = out_done_ff;
   assign rsp_run_truncated = out_trunc_ff;

endmodule

`default_nettype wire

FILE: hdl/cjkwj_control.sv
`timescale 1ns / 1ps
`default_nettype none

module cjkwj_control (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire cjkwj_pkg::status_type  status,
   output cjkwj_pkg::cmd_type          cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HIGH,
      ST_UNIT
   } state_type;

   state_type state_ff, state_in;
   logic      high_ff, high_in;
   logic      unit_ff, unit_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      high_in     = high_ff;
      unit_in     = unit_ff;
      cmd.accept  = accept;
      cmd.emit    = 1'b0;
      cmd.src     = cjkwj_pkg::SRC_UNIT;
      cmd.last    = 1'b0;
      cmd.wr_pend = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               high_in = status.plan_high;
               unit_in = status.plan_unit;
               if (status.plan_run) begin
                  state_in = ST_RUN;
               end else if (status.plan_high) begin
                  state_in = ST_HIGH;
               end else if (status.plan_unit) begin
                  state_in = ST_UNIT;
               end
            end
         end
         ST_RUN: begin
            cmd.src = cjkwj_pkg::SRC_RUN;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = status.run_last && !high_ff && !unit_ff;
               if (status.run_last) begin
                  if (high_ff) begin
                     state_in = ST_HIGH;
                  end else if (unit_ff) begin
                     state_in = ST_UNIT;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_HIGH: begin
            // The old run has been read out, so a deferred entry can go in now.
            cmd.src     = cjkwj_pkg::SRC_HIGH;
            cmd.wr_pend = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = !unit_ff;
               state_in = unit_ff ? ST_UNIT : ST_IDLE;
            end
         end
         ST_UNIT: begin
            cmd.src = cjkwj_pkg::SRC_UNIT;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         high_ff  <= 1'b0;
         unit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         high_ff  <= high_in;
         unit_ff  <= unit_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/cjk_whitespace_joiner.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Joins CJK text split by whitespace in a stream of UTF-16 code units. A run of
// space, tab, CR or LF is held in a RUN_DEPTH-entry run store and dropped when
// the code points on both sides of it are CJK (surrogate pairs count as one code
// point); otherwise it is replayed in order ahead of the unit that ended it. A
// high surrogate after a run waits for the next request. At page end everything
// held is flushed. Units beyond RUN_DEPTH in one run are lost and run_truncated
// marks every result of the request that resolves that run. A request is taken
// only while the controller is idle and yields from 0 to RUN_DEPTH + 2 results;
// no new request is taken until its last result is loaded. Replayed whitespace
// streams from the run store's registered read port at one unit per cycle while
// the result side keeps up. The result register lets the last result of a
// request wait while the next request is taken.

module cjk_whitespace_joiner #(
   parameter int RUN_DEPTH = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   cjkwj_req_if.sink   req_ch,
   cjkwj_rsp_if.source rsp_ch
);

   cjkwj_pkg::cmd_type    ctrl_cmd;
   cjkwj_pkg::status_type dp_status;
   logic                  req_ready;

   cjkwj_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   cjkwj_datapath #(
      .RUN_DEPTH (RUN_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_code_unit     (req_ch.code_unit),
      .req_page_end      (req_ch.page_end),
      .cmd               (ctrl_cmd),
      .status            (dp_status),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_out_unit      (rsp_ch.out_unit),
      .rsp_last_of_item  (rsp_ch.last_of_item),
      .rsp_page_done     (rsp_ch.page_done),
      .rsp_run_truncated (rsp_ch.run_truncated)
   );

   assign req_ch.ready = req_ready;

   // A result is only loaded when the result register has room.
   `ASSERT_IMPLY(a_emit_has_room, clock, reset, ctrl_cmd.emit, dp_status.out_free,
                 "result loaded over a waiting result")
   // No request is taken while results of the previous one are still being produced.
   `ASSERT_IMPLY(a_emit_not_idle, clock, reset, ctrl_cmd.emit, !req_ready,
                 "result produced while the controller is idle")
   // After the final result of a request the controller is ready again.
   `ASSERT_NEXT(a_last_then_ready, clock, reset, ctrl_cmd.emit && ctrl_cmd.last, req_ready,
                "controller did not return to idle after the final result")

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int RUN_DEPTH   = 32;
   localparam int RANDOM_N    = 184;
   localparam int STUCK_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct packed {
      logic [15:0] unit;
      logic        last;
      logic        done;
      logic        trunc;
   } joined_unit_type;

   // Tracks what the joiner should emit: its own copy of the held run, the held
   // high surrogate and the CJK status of the previous code point.
   class cjk_join_tracker;
      bit              prev_cjk;
      bit [1:0]        run_codes[RUN_DEPTH];
      int              run_len;
      bit              high_held;
      bit [15:0]       high_unit;
      bit              pair_open;
      bit              run_lost;
      bit              step_trunc;
      joined_unit_type step_q[$];
      joined_unit_type joined_units_q[$];
      int              errors;

      function bit cjk_point(logic [20:0] cp);
         return (cp >= cjkwj_pkg::CJK_A_LO && cp <= cjkwj_pkg::CJK_A_HI) ||
                (cp >= cjkwj_pkg::CJK_B_LO && cp <= cjkwj_pkg::CJK_B_HI) ||
                (cp >= cjkwj_pkg::CJK_C_LO && cp <= cjkwj_pkg::CJK_C_HI);
      endfunction

      function bit high_sur(logic [15:0] u);
         return u >= cjkwj_pkg::HIGH_LO && u <= cjkwj_pkg::HIGH_HI;
      endfunction

      function bit low_sur(logic [15:0] u);
         return u >= cjkwj_pkg::LOW_LO && u <= cjkwj_pkg::LOW_HI;
      endfunction

      function logic [20:0] joined(logic [15:0] hi, logic [15:0] lo);
         logic [20:0] h;
         logic [20:0] l;
         h = 21'(hi) - 21'(cjkwj_pkg::HIGH_LO);
         l = 21'(lo) - 21'(cjkwj_pkg::LOW_LO);
         return cjkwj_pkg::SUPP_BASE + (h << 10) + l;
      endfunction

      function int ws_index(logic [15:0] u);
         case (u)
            cjkwj_pkg::UNIT_SPACE: return int'(cjkwj_pkg::WS_SPACE);
            cjkwj_pkg::UNIT_TAB:   return int'(cjkwj_pkg::WS_TAB);
            cjkwj_pkg::UNIT_CR:    return int'(cjkwj_pkg::WS_CR);
            cjkwj_pkg::UNIT_LF:    return int'(cjkwj_pkg::WS_LF);
            default:               return -1;
         endcase
      endfunction

      function logic [15:0] ws_char(logic [1:0] c);
         case (c)
            cjkwj_pkg::WS_SPACE: return cjkwj_pkg::UNIT_SPACE;
            cjkwj_pkg::WS_TAB:   return cjkwj_pkg::UNIT_TAB;
            cjkwj_pkg::WS_CR:    return cjkwj_pkg::UNIT_CR;
            default:             return cjkwj_pkg::UNIT_LF;
         endcase
      endfunction

      function void put(logic [15:0] u);
         joined_unit_type r;
         r = '{unit: u, last: 1'b0, done: 1'b0, trunc: 1'b0};
         if (step_q.size() < RUN_DEPTH + 2) step_q.push_back(r);
      endfunction

      // Either replays the held run or drops it; the run is gone afterwards.
      function void settle_run(bit drop);
         if (!drop)
            for (int i = 0; i < run_len; i++) put(ws_char(run_codes[i]));
         if (run_lost) step_trunc = 1'b1;
         run_len = 0;
         run_lost = 1'b0;
      endfunction

      function void take(logic [15:0] u);
         int code;
         bit c;
         code = ws_index(u);
         if (code >= 0) begin
            pair_open = 1'b0;
            if (run_len < RUN_DEPTH) begin
               run_codes[run_len] = code[1:0];
               run_len++;
            end else begin
               run_lost = 1'b1;
            end
            return;
         end
         if (run_len > 0) begin
            // A high surrogate after a run must wait for its partner to be classified.
            if (high_sur(u)) begin
               high_held = 1'b1;
               high_unit = u;
               return;
            end
            c = cjk_point({5'd0, u});
            settle_run(prev_cjk && c);
            put(u);
            prev_cjk = c;
            pair_open = 1'b0;
            return;
         end
         if (pair_open && low_sur(u)) begin
            put(u);
            prev_cjk = cjk_point(joined(high_unit, u));
            pair_open = 1'b0;
            return;
         end
         put(u);
         if (high_sur(u)) begin
            pair_open = 1'b1;
            high_unit = u;
            prev_cjk = 1'b0;
         end else begin
            pair_open = 1'b0;
            prev_cjk = cjk_point({5'd0, u});
         end
      endfunction

      function void absorb_unit(logic [15:0] u, logic page_end);
         bit pair_cjk;
         step_q.delete();
         step_trunc = 1'b0;
         if (high_held) begin
            high_held = 1'b0;
            if (low_sur(u)) begin
               pair_cjk = cjk_point(joined(high_unit, u));
               settle_run(prev_cjk && pair_cjk);
               put(high_unit);
               put(u);
               prev_cjk = pair_cjk;
               pair_open = 1'b0;
            end else begin
               settle_run(1'b0);
               put(high_unit);
               prev_cjk = 1'b0;
               pair_open = 1'b0;
               take(u);
            end
         end else begin
            take(u);
         end
         if (page_end) begin
            if (high_held) begin
               settle_run(1'b0);
               put(high_unit);
               high_held = 1'b0;
            end else if (run_len > 0) begin
               settle_run(1'b0);
            end
            run_len = 0;
            run_lost = 1'b0;
            prev_cjk = 1'b0;
            pair_open = 1'b0;
         end
         foreach (step_q[k]) step_q[k].trunc = step_trunc;
         if (step_q.size() > 0) begin
            step_q[step_q.size() - 1].last = 1'b1;
            if (page_end) step_q[step_q.size() - 1].done = 1'b1;
         end
         foreach (step_q[k]) joined_units_q.push_back(step_q[k]);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 30) $display("ERROR at %0t: %s", $time, msg);
      endtask

      task match_output(joined_unit_type got);
         joined_unit_type want;
         if (joined_units_q.size() == 0) begin
            report($sformatf("unexpected unit %h last=%b page_done=%b truncated=%b",
                             got.unit, got.last, got.done, got.trunc));
            return;
         end
         want = joined_units_q.pop_front();
         if (got !== want)
            report($sformatf({"got unit %h last=%b page_done=%b truncated=%b, ",
                              "expected unit %h last=%b page_done=%b truncated=%b"},
                             got.unit, got.last, got.done, got.trunc,
                             want.unit, want.last, want.done, want.trunc));
      endtask

      function int pending();
         return joined_units_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic [15:0] req_unit  = '0;
   logic        req_end   = 1'b0;
   logic        rsp_go    = 1'b0;
   bit          calm      = 1'b0;
   int          units_sent;
   int          stuck;

   cjk_join_tracker board = new();

   cjkwj_req_if req_ch();
   cjkwj_rsp_if rsp_ch();

   assign req_ch.valid     = req_valid;
   assign req_ch.code_unit = req_unit;
   assign req_ch.page_end  = req_end;
   assign rsp_ch.ready     = rsp_go;

   cjk_whitespace_joiner #(.RUN_DEPTH(RUN_DEPTH)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_go <= 1'b0;
      else rsp_go <= calm || ($urandom_range(0, 99) >= 25);
   end

   // Results are checked before the request of the same edge is noted, since the
   // last result of one request can leave as the next request is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.match_output('{unit: rsp_ch.out_unit, last: rsp_ch.last_of_item,
                                 done: rsp_ch.page_done, trunc: rsp_ch.run_truncated});
         if (req_ch.valid && req_ch.ready)
            board.absorb_unit(req_ch.code_unit, req_ch.page_end);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck <= 0;
      end else if (stuck == STUCK_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stuck <= stuck + 1;
      end
   end

   task automatic send_unit(input logic [15:0] u, input logic page_end);
      while (!calm && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_unit <= u;
      req_end <= page_end;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      units_sent++;
   endtask

   // Holds requests back until every expected unit has come out.
   task automatic drain();
      do begin
         req_valid <= 1'b0;
         @(posedge clock);
      end while (board.pending() > 0);
   endtask

   function automatic logic page_flip();
      return $urandom_range(0, 11) == 0;
   endfunction

   function automatic logic [15:0] ws_pick();
      case ($urandom_range(0, 3))
         0:       return cjkwj_pkg::UNIT_SPACE;
         1:       return cjkwj_pkg::UNIT_TAB;
         2:       return cjkwj_pkg::UNIT_CR;
         default: return cjkwj_pkg::UNIT_LF;
      endcase
   endfunction

   // One piece of page text: a CJK character or a unit at a CJK block edge, a surrogate
   // pair, a whitespace run, an arbitrary unit or a lone surrogate.
   task automatic send_token();
      int          pick;
      int          len;
      logic [15:0] u;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         case ($urandom_range(0, 5))
            0: u = 16'($urandom_range(cjkwj_pkg::CJK_B_LO, cjkwj_pkg::CJK_B_HI));
            1: begin
               case ($urandom_range(0, 5))
                  0:       u = 16'h33FF;
                  1:       u = 16'hA000;
                  2:       u = 16'hF8FF;
                  3:       u = 16'hFB00;
                  4:       u = cjkwj_pkg::CJK_A_LO;
                  default: u = cjkwj_pkg::CJK_B_HI;
               endcase
            end
            default: u = 16'($urandom_range(cjkwj_pkg::CJK_A_LO, cjkwj_pkg::CJK_A_HI));
         endcase
         send_unit(u, page_flip());
      end else if (pick < 45) begin
         // High units around the span that pairs into the supplementary CJK block.
         send_unit(16'($urandom_range(16'hD83F, 16'hD889)), page_flip());
         send_unit(16'($urandom_range(cjkwj_pkg::LOW_LO, cjkwj_pkg::LOW_HI)), page_flip());
      end else if (pick < 70) begin
         if ($urandom_range(0, 5) == 0) len = $urandom_range(RUN_DEPTH - 1, RUN_DEPTH + 4);
         else len = $urandom_range(1, 4);
         for (int i = 0; i < len; i++)
            send_unit(ws_pick(), (i == len - 1) ? page_flip() : 1'b0);
      end else if (pick < 85) begin
         send_unit(16'($urandom_range(0, 16'hFFFF)), page_flip());
      end else if (pick < 93) begin
         send_unit(16'($urandom_range(cjkwj_pkg::HIGH_LO, cjkwj_pkg::HIGH_HI)), page_flip());
      end else begin
         send_unit(16'($urandom_range(cjkwj_pkg::LOW_LO, cjkwj_pkg::LOW_HI)), page_flip());
      end
   endtask

   initial begin
      int base;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_unit(16'h0000, 1'b0);
      send_unit(16'hFFFF, 1'b0);
      // CJK, space, CJK: the space disappears.
      send_unit(cjkwj_pkg::CJK_A_LO, 1'b0);
      send_unit(cjkwj_pkg::UNIT_SPACE, 1'b0);
      send_unit(cjkwj_pkg::CJK_A_HI, 1'b0);
      send_unit(cjkwj_pkg::UNIT_TAB, 1'b0);
      send_unit(cjkwj_pkg::UNIT_CR, 1'b0);
      send_unit(cjkwj_pkg::CJK_B_LO, 1'b0);
      // Runs ended by surrogate pairs at both ends of the supplementary CJK block.
      send_unit(cjkwj_pkg::UNIT_LF, 1'b0);
      send_unit(16'hD840, 1'b0);
      send_unit(16'hDC00, 1'b0);
      send_unit(cjkwj_pkg::UNIT_SPACE, 1'b0);
      send_unit(16'hD888, 1'b0);
      send_unit(16'hDFAF, 1'b0);
      // Lone low surrogate, then a pair outside any CJK block.
      send_unit(16'hDFFF, 1'b0);
      send_unit(16'hD8C0, 1'b0);
      send_unit(16'hDC00, 1'b0);
      // Held high surrogate that turns out to be unpaired.
      send_unit(cjkwj_pkg::UNIT_SPACE, 1'b0);
      send_unit(16'hDBFF, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(cjkwj_pkg::CJK_B_HI, 1'b0);
      // Page ends with a run held, with a high surrogate held, and on a plain unit.
      send_unit(cjkwj_pkg::UNIT_LF, 1'b0);
      send_unit(cjkwj_pkg::UNIT_SPACE, 1'b1);
      send_unit(cjkwj_pkg::UNIT_SPACE, 1'b0);
      send_unit(16'hDBFF, 1'b1);
      send_unit(16'h4E00, 1'b1);

      drain();

      base = units_sent;
      while (units_sent - base < RANDOM_N) begin
         calm = (units_sent - base >= 80) && (units_sent - base < 140);
         send_token();
      end
      calm = 1'b0;

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: cjk_whitespace_joiner.f
+incdir+hdl
hdl/cjkwj_pkg.sv
hdl/cjkwj_channels.sv
hdl/cjkwj_datapath.sv
hdl/cjkwj_control.sv
hdl/cjk_whitespace_joiner.sv
dv/tb.sv
